@@ hw/rtl/noncontinuous_rastrigin_eval_defines.svh @@
// assertion macros shared by the noncontinuous rastrigin evaluator
// no dependencies; included by modules that carry concurrent checks
`ifndef NONCONTINUOUS_RASTRIGIN_EVAL_DEFINES_SVH
`define NONCONTINUOUS_RASTRIGIN_EVAL_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define NRE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define NRE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/nrast_pkg.sv @@
// shared types, constants and elaboration-time table math for the evaluator
// no dependencies
`default_nettype none

package nrast_pkg;

    localparam int  SUM_W     = 40;
    localparam int  COORD_W   = 16;
    localparam int  BIAS_W    = 32;
    localparam int  CFG_DW    = 32;
    localparam int  CFG_AW    = 3;

    // register index, taken from paddr[2]
    localparam logic REG_BIAS = 1'b0;

    localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    localparam longint Q30_ONE    = longint'(1) << 30;
    localparam longint TWO_PI_Q30 = 64'sd6746518852;
    localparam longint COS_DIVS [6] = '{132, 90, 56, 30, 12, 2};

    typedef struct packed {
        logic valid;
        logic last;
    } t_ctl;

    // cos(2*pi*u / 2^frac) in q30 for 0 <= u <= 2^(frac-2), nested taylor form
    function automatic longint cos_quarter(int frac, longint u);
        longint th;
        longint t2;
        longint r;
        th = (u * TWO_PI_Q30 + (longint'(1) << (frac - 1))) >>> frac;
        t2 = (th * th + (longint'(1) << 29)) >>> 30;
        r  = Q30_ONE;
        for (int i = 0; i < 6; i++) begin
            r = Q30_ONE - (t2 / COS_DIVS[i]) * r / Q30_ONE;
        end
        if (r > Q30_ONE) begin
            r = Q30_ONE;
        end
        if (r < -Q30_ONE) begin
            r = -Q30_ONE;
        end
        return r;
    endfunction

    // full term x*x + 10 - 10*cos(2*pi*x) for a magnitude below one half
    function automatic longint term_value(int frac, longint a);
        longint half;
        longint quarter;
        longint sq;
        longint cs;
        longint v;
        half    = longint'(1) << (frac - 1);
        quarter = longint'(1) << (frac - 2);
        sq      = (a * a + half) >>> frac;
        if (a <= quarter) begin
            cs = cos_quarter(frac, a);
        end else begin
            cs = -cos_quarter(frac, half - a);
        end
        v = 10 * (Q30_ONE - cs);
        v = (v + (longint'(1) << (29 - frac))) >>> (30 - frac);
        return sq + v;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/nrast_term.sv @@
// input register and per-coordinate term stage: snapping, square, table lookup
// depends on nrast_pkg
`default_nettype none

module nrast_term import nrast_pkg::*; #(
    parameter int FRAC_BITS = 12
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_adv,
    input  wire logic               i_valid,
    input  wire logic               i_last,
    input  wire logic [COORD_W-1:0] i_coord,
    output t_ctl                    o_ctl,
    output logic [SUM_W-1:0]        o_term
);

    localparam int ROM_AW    = (FRAC_BITS - 1 < 16) ? FRAC_BITS - 1 : 16;
    localparam int ROM_DEPTH = 1 << ROM_AW;
    localparam int TW        = FRAC_BITS + 6;

    localparam logic [20:0]      HALF_W  = 21'd1 << (FRAC_BITS - 1);
    localparam logic [SUM_W-1:0] ODD_ADD = 40'd20 << FRAC_BITS;

    typedef logic [TW-1:0] t_rom [ROM_DEPTH];

    function automatic t_rom build_rom();
        t_rom   rom;
        longint v;
        for (int i = 0; i < ROM_DEPTH; i++) begin
            v      = term_value(FRAC_BITS, longint'(i));
            rom[i] = v[TW-1:0];
        end
        return rom;
    endfunction

    localparam t_rom TERM_ROM = build_rom();

    t_ctl               r_a_ctl;
    logic [COORD_W-1:0] r_coord;
    t_ctl               r_b_ctl;
    logic               r_small;
    logic [TW-1:0]      r_rom;
    logic [SUM_W-1:0]   r_snap;

    logic [COORD_W-1:0] w_a;
    logic [20:0]        w_twice;
    logic [20:0]        w_n_full;
    logic [12:0]        w_n;
    logic [25:0]        w_sq;
    logic [SUM_W-1:0]   n_snap;
    logic               n_small;

    always_comb begin
        w_a      = r_coord[COORD_W-1] ? (~r_coord + 16'd1) : r_coord;
        n_small  = {5'b0, w_a} < HALF_W;
        // round 2|x| half away from zero, then square of n/2, plus 20 when n is odd
        w_twice  = {4'b0, w_a, 1'b0} + HALF_W;
        w_n_full = w_twice >> FRAC_BITS;
        w_n      = w_n_full[12:0];
        w_sq     = {13'b0, w_n} * {13'b0, w_n};
        n_snap   = ({14'b0, w_sq} << (FRAC_BITS - 2)) + (w_n[0] ? ODD_ADD : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_ctl <= '0;
            r_b_ctl <= '0;
        end else if (i_adv) begin
            r_a_ctl <= '{valid: i_valid, last: i_last};
            r_b_ctl <= r_a_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_coord <= i_coord;
            r_small <= n_small;
            r_snap  <= n_snap;
            r_rom   <= TERM_ROM[w_a[ROM_AW-1:0]];
        end
    end

    assign o_ctl  = r_b_ctl;
    assign o_term = r_small ? SUM_W'(r_rom) : r_snap;

endmodule

`default_nettype wire

@@ hw/rtl/nrast_acc.sv @@
// running sum, final total register and biased, saturated output register
// depends on nrast_pkg and the assertion macro header
`default_nettype none

`include "noncontinuous_rastrigin_eval_defines.svh"

module nrast_acc import nrast_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  t_ctl                   i_ctl,
    input  wire logic [SUM_W-1:0]  i_term,
    input  wire logic [BIAS_W-1:0] i_bias,
    input  wire logic              i_m_tready,
    output logic                   o_adv,
    output logic                   o_m_tvalid,
    output logic [SUM_W-1:0]       o_m_tdata
);

    logic [SUM_W-1:0] r_acc;
    logic [SUM_W-1:0] r_tot;
    logic             r_tot_valid;
    logic [SUM_W-1:0] r_out;
    logic             r_out_valid;

    logic [SUM_W:0]   w_sum_full;
    logic [SUM_W-1:0] n_sum;
    logic [SUM_W:0]   w_fin_full;
    logic [SUM_W-1:0] n_out;
    logic             w_out_load;

    always_comb begin
        // the sum never goes negative, so only the top end can clip
        w_sum_full = {1'b0, r_acc} + {1'b0, i_term};
        n_sum      = (w_sum_full > {1'b0, SUM_MAX}) ? SUM_MAX : w_sum_full[SUM_W-1:0];

        w_fin_full = {r_tot[SUM_W-1], r_tot}
                   + {{(SUM_W + 1 - BIAS_W){i_bias[BIAS_W-1]}}, i_bias};
        if (w_fin_full[SUM_W] != w_fin_full[SUM_W-1]) begin
            n_out = w_fin_full[SUM_W] ? SUM_MIN : SUM_MAX;
        end else begin
            n_out = w_fin_full[SUM_W-1:0];
        end

        w_out_load = !r_out_valid || i_m_tready;
        // hold the pipe only when a total is waiting behind a full output
        o_adv      = !(r_tot_valid && !w_out_load);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_tot_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_adv) begin
                r_tot_valid <= i_ctl.valid && i_ctl.last;
                if (i_ctl.valid) begin
                    r_acc <= i_ctl.last ? '0 : n_sum;
                end
            end
            if (w_out_load) begin
                r_out_valid <= r_tot_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv && i_ctl.valid && i_ctl.last) begin
            r_tot <= n_sum;
        end
        if (w_out_load && r_tot_valid) begin
            r_out <= n_out;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out;

    `NRE_ASSERT_IMP(a_acc_nonneg, i_clk, i_rst_n, 1'b1, !r_acc[SUM_W-1], "running sum went negative")
    `NRE_ASSERT_NEXT(a_acc_clear, i_clk, i_rst_n, o_adv && i_ctl.valid && i_ctl.last, r_acc == '0, "sum not cleared after last item")
    `NRE_ASSERT_NEXT(a_tot_moves, i_clk, i_rst_n, r_tot_valid && !r_out_valid, r_out_valid, "pending total not moved to output")

endmodule

`default_nettype wire

@@ hw/rtl/noncontinuous_rastrigin_eval.sv @@
// noncontinuous rastrigin evaluator: one coordinate per cycle unless stalled, one result per vector
// a vector's result goes through the input, term-stage, total and output registers to o_m_tvalid
// throughput: 1 item per cycle while the pipe advances, set by the advance signal from nrast_acc
// output stall holds the pipe only while a finished total waits behind a full output register
// reset (synchronous, active low) clears the running sum, the bias register and all valids
// depends on nrast_pkg, nrast_term and nrast_acc
`default_nettype none

module noncontinuous_rastrigin_eval import nrast_pkg::*; #(
    parameter int FRAC_BITS = 12
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // stream in
    input  wire logic              i_s_tvalid,
    output logic                   o_s_tready,
    input  wire logic [15:0]       i_s_tdata,   // [15:0] coord
    input  wire logic              i_s_tlast,   // last
    // stream out
    output logic                   o_m_tvalid,
    input  wire logic              i_m_tready,
    output logic [39:0]            o_m_tdata,   // [39:0] fitness
    // configuration
    input  wire logic              i_psel,
    input  wire logic              i_penable,
    input  wire logic              i_pwrite,
    input  wire logic [CFG_AW-1:0] i_paddr,
    input  wire logic [CFG_DW-1:0] i_pwdata,
    output logic [CFG_DW-1:0]      o_prdata,
    output logic                   o_pready
);

    logic [BIAS_W-1:0] r_bias;
    logic              w_adv;
    t_ctl              w_ctl;
    logic [SUM_W-1:0]  w_term;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bias <= '0;
        end else if (i_psel && i_penable && i_pwrite && i_paddr[2] == REG_BIAS) begin
            r_bias <= i_pwdata;
        end
    end

    always_comb begin
        unique case (i_paddr[2])
            REG_BIAS: o_prdata = r_bias;
            default:  o_prdata = '0;
        endcase
    end

    assign o_pready   = 1'b1;
    assign o_s_tready = w_adv;

    nrast_term #(
        .FRAC_BITS (FRAC_BITS)
    ) u_term (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (i_s_tvalid),
        .i_last  (i_s_tlast),
        .i_coord (i_s_tdata),
        .o_ctl   (w_ctl),
        .o_term  (w_term)
    );

    nrast_acc u_acc (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .i_term     (w_term),
        .i_bias     (r_bias),
        .i_m_tready (i_m_tready),
        .o_adv      (w_adv),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata)
    );

endmodule

`default_nettype wire
